// ----- rtl/lspe_pkg.sv -----
package lspe_pkg;

  localparam int unsigned Channels = 8;
  localparam int unsigned ChW = $clog2(Channels);
  localparam int unsigned RawW = 10;
  localparam int unsigned LevelW = 10;
  localparam int unsigned PosW = 13;
  localparam int unsigned CountW = 4;
  localparam int unsigned FirstW = 4;
  localparam int unsigned LastW = 3;
  localparam int unsigned QuotW = 11;
  localparam int unsigned NumW = 20;
  localparam int unsigned WsumW = 27;
  localparam int unsigned LsumW = 14;
  localparam int unsigned PosQW = 13;

  localparam logic [RawW-1:0] MinReset = 10'd1023;
  localparam logic [RawW-1:0] MaxReset = 10'd0;
  localparam logic [LevelW-1:0] FullScale = 10'd1000;
  localparam logic [LevelW-1:0] ThreshReset = 10'd600;
  localparam logic [PosW-1:0] CenterPos = PosW'((Channels - 1) * 500);

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpCalibrate = 2'd1,
    OpMeasure = 2'd2,
    OpUnused = 2'd3
  } opcode_e;

  // Lane control from the sequencer.
  typedef struct packed {
    logic clear;
    logic calibrate;
    logic start;
  } lane_ctrl_t;

endpackage

// ----- rtl/lspe_lane.sv -----
module lspe_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lspe_pkg::lane_ctrl_t            ctrl_i,
  input  logic                            step_i,
  input  logic [lspe_pkg::RawW-1:0]       raw_i,
  output logic [lspe_pkg::LevelW-1:0]     level_o
);

  logic [lspe_pkg::RawW-1:0] min_q, min_d, max_q, max_d;
  logic [lspe_pkg::NumW:0]   rem_q, rem_d;
  logic [lspe_pkg::RawW-1:0] den_q, den_d;
  logic [lspe_pkg::QuotW-1:0] quo_q, quo_d;
  logic                      cal_q, cal_d;
  logic [lspe_pkg::RawW-1:0] new_min;
  logic [lspe_pkg::RawW-1:0] eff_raw;
  logic [lspe_pkg::NumW+1:0] trial;

  // A sample above the max is clamped there; it would saturate anyway.
  always_comb begin
    new_min = (raw_i < min_q) ? raw_i : min_q;
    eff_raw = (raw_i > max_q) ? max_q : raw_i;
  end

  // Calibration state and a restoring divider, one quotient bit a step.
  always_comb begin
    min_d = min_q;
    max_d = max_q;
    rem_d = rem_q;
    den_d = den_q;
    quo_d = quo_q;
    cal_d = cal_q;
    trial = '0;
    if (ctrl_i.clear) begin
      min_d = lspe_pkg::MinReset;
      max_d = lspe_pkg::MaxReset;
    end else if (ctrl_i.calibrate) begin
      min_d = new_min;
      max_d = (raw_i > max_q) ? raw_i : max_q;
    end else if (ctrl_i.start) begin
      cal_d = max_q > min_q;
      quo_d = '0;
      if (max_q > min_q) begin
        min_d = new_min;
        rem_d = {1'b0, lspe_pkg::NumW'(eff_raw - new_min) *
                       lspe_pkg::NumW'(lspe_pkg::FullScale)};
        den_d = max_q - new_min;
      end else begin
        rem_d = '0;
        den_d = '1;
      end
    end else if (step_i) begin
      // The quotient is at most 1000, so eleven bits against the divisor
      // shifted by ten cover it; the remainder stays below twice that divisor.
      trial = {1'b0, rem_q} - ({{(lspe_pkg::NumW+2-lspe_pkg::RawW){1'b0}}, den_q}
              << (lspe_pkg::QuotW - 1));
      if (!trial[lspe_pkg::NumW+1]) begin
        rem_d = {trial[lspe_pkg::NumW-1:0], 1'b0};
        quo_d = {quo_q[lspe_pkg::QuotW-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[lspe_pkg::QuotW-2:0], 1'b0};
        rem_d = {rem_q[lspe_pkg::NumW-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= lspe_pkg::MinReset;
      max_q <= lspe_pkg::MaxReset;
      cal_q <= 1'b0;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
      cal_q <= cal_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  // Zero until calibrated; otherwise saturate at full scale.
  always_comb begin
    if (!cal_q) begin
      level_o = '0;
    end else if (quo_q > lspe_pkg::QuotW'(lspe_pkg::FullScale)) begin
      level_o = lspe_pkg::FullScale;
    end else begin
      level_o = quo_q[lspe_pkg::LevelW-1:0];
    end
  end

endmodule

// ----- rtl/lspe_merge.sv -----
module lspe_merge (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  logic [lspe_pkg::Channels-1:0][lspe_pkg::LevelW-1:0] level_i,
  input  logic [lspe_pkg::LevelW-1:0]                  thresh_i,
  output logic                                         done_o,
  output logic [lspe_pkg::PosW-1:0]                    pos_o,
  output logic [lspe_pkg::CountW-1:0]                  count_o,
  output logic [lspe_pkg::FirstW-1:0]                  first_o,
  output logic [lspe_pkg::LastW-1:0]                   last_o
);

  localparam int unsigned WalkW = $clog2(lspe_pkg::Channels + 1);

  logic [WalkW-1:0]          idx_q, idx_d;
  logic                      walk_q, walk_d, div_q, div_d;
  logic [4:0]                bit_q, bit_d;
  logic [lspe_pkg::WsumW-1:0] wsum_q, wsum_d;
  logic [lspe_pkg::LsumW-1:0] lsum_q, lsum_d;
  logic [lspe_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [lspe_pkg::FirstW-1:0] first_q, first_d;
  logic [lspe_pkg::LastW-1:0]  last_q, last_d;
  logic [lspe_pkg::WsumW-1:0] rem_q, rem_d;
  logic [lspe_pkg::PosQW-1:0] quo_q, quo_d;
  logic                      done_q, done_d;
  logic [lspe_pkg::LevelW-1:0] lvl;
  logic [lspe_pkg::WsumW:0]  trial;
  logic [lspe_pkg::WsumW-1:0] weight;

  always_comb begin
    lvl = level_i[idx_q[lspe_pkg::ChW-1:0]];
    weight = lspe_pkg::WsumW'(idx_q[lspe_pkg::ChW-1:0]) * lspe_pkg::WsumW'(1000);
  end

  // Walk the lanes one a cycle, then divide one quotient bit a cycle.
  always_comb begin
    idx_d = idx_q; walk_d = walk_q; div_d = div_q; bit_d = bit_q;
    wsum_d = wsum_q; lsum_d = lsum_q; cnt_d = cnt_q;
    first_d = first_q; last_d = last_q; rem_d = rem_q; quo_d = quo_q;
    done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      idx_d = '0; walk_d = 1'b1; wsum_d = '0; lsum_d = '0; cnt_d = '0;
      first_d = lspe_pkg::FirstW'(8); last_d = '0;
    end else if (walk_q) begin
      if (lvl > thresh_i) begin
        wsum_d = wsum_q + lspe_pkg::WsumW'(lvl) * weight;
        lsum_d = lsum_q + lspe_pkg::LsumW'(lvl);
        cnt_d = cnt_q + 1'b1;
        if (first_q == lspe_pkg::FirstW'(8)) begin
          first_d = lspe_pkg::FirstW'(idx_q[lspe_pkg::ChW-1:0]);
        end
        last_d = lspe_pkg::LastW'(idx_q[lspe_pkg::ChW-1:0]);
      end
      idx_d = idx_q + 1'b1;
      if (idx_q == WalkW'(lspe_pkg::Channels - 1)) begin
        walk_d = 1'b0; div_d = 1'b1;
        bit_d = 5'(lspe_pkg::PosQW - 1);
        rem_d = wsum_d; quo_d = '0;
      end
    end else if (div_q) begin
      trial = {1'b0, rem_q} - ({{(lspe_pkg::WsumW+1-lspe_pkg::LsumW){1'b0}}, lsum_q} << bit_q);
      quo_d = {quo_q[lspe_pkg::PosQW-2:0], ~trial[lspe_pkg::WsumW]};
      if (!trial[lspe_pkg::WsumW]) rem_d = trial[lspe_pkg::WsumW-1:0];
      bit_d = bit_q - 1'b1;
      if (bit_q == '0) begin
        div_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= 1'b0; div_q <= 1'b0; done_q <= 1'b0;
    end else begin
      walk_q <= walk_d; div_q <= div_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; bit_q <= bit_d; wsum_q <= wsum_d; lsum_q <= lsum_d;
    cnt_q <= cnt_d; first_q <= first_d; last_q <= last_d;
    rem_q <= rem_d; quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign pos_o = (cnt_q == '0 || lsum_q == '0) ? lspe_pkg::CenterPos : quo_q;
  assign count_o = cnt_q;
  assign first_o = first_q;
  assign last_o = last_q;

`ifndef ASSERT_OFF
  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(walk_q && div_q)) else $error("walk and divide overlap");
  a_done_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(div_q)) else $error("done without divide");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q <= lspe_pkg::CountW'(lspe_pkg::Channels)) else $error("count range");
`endif

endmodule

// ----- rtl/line_sensor_position_estimator.sv -----
// Timing: clear, calibrate and the unused opcode complete at the accepting edge
// and give no item; a measure item becomes valid after the lane divider steps,
// the lane walk, the position divider steps and the output register.
// Items: no new item is accepted while a measure is in progress or a result
// waits on the output; the dividers are bit-serial. Reset: asynchronous active low;
// min levels go to 1023, max levels to 0, black threshold to 600, no item is held.
module line_sensor_position_estimator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,     // line_level [9:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // raw_ch0..raw_ch7, 10 bits each
  input  logic [1:0]  s_axis_tuser,   // opcode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // line_position, black_count, first_black,
                                      // last_black, left_edge_level, right_edge_level
);

  localparam int unsigned DivCycles = lspe_pkg::QuotW;

  logic [lspe_pkg::LevelW-1:0] thresh_q;
  logic                        busy_q, busy_d;
  logic [3:0]                  cnt_q, cnt_d;
  logic                        ovalid_q, ovalid_d;
  logic [47:0]                 odata_q;
  logic                        accept, lane_step, merge_start, merge_done;
  lspe_pkg::opcode_e           op;
  lspe_pkg::lane_ctrl_t        lctrl;
  logic [lspe_pkg::Channels-1:0][lspe_pkg::LevelW-1:0] levels;
  logic [lspe_pkg::PosW-1:0]   pos;
  logic [lspe_pkg::CountW-1:0] count;
  logic [lspe_pkg::FirstW-1:0] first;
  logic [lspe_pkg::LastW-1:0]  last;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = !busy_q && !ovalid_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign op = lspe_pkg::opcode_e'(s_axis_tuser);

  always_comb begin
    lctrl.clear = accept && op == lspe_pkg::OpClear;
    lctrl.calibrate = accept && op == lspe_pkg::OpCalibrate;
    lctrl.start = accept && op == lspe_pkg::OpMeasure;
  end

  // Lanes, one per channel.
  for (genvar g = 0; g < lspe_pkg::Channels; g++) begin : g_lane
    logic [lspe_pkg::RawW-1:0] raw;
    if (g < 8) begin : g_in
      assign raw = s_axis_tdata[g*lspe_pkg::RawW +: lspe_pkg::RawW];
    end else begin : g_zero
      assign raw = '0;
    end
    lspe_lane u_lane (
      .clk_i, .rst_ni, .ctrl_i(lctrl), .step_i(lane_step), .raw_i(raw),
      .level_o(levels[g])
    );
  end

  // Sequencer: lane division, then merge.
  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; lane_step = 1'b0; merge_start = 1'b0;
    if (lctrl.start) begin
      busy_d = 1'b1; cnt_d = '0;
    end else if (busy_q && cnt_q < 4'(DivCycles)) begin
      lane_step = 1'b1; cnt_d = cnt_q + 1'b1;
      if (cnt_q == 4'(DivCycles - 1)) merge_start = 1'b1;
    end else if (merge_done) begin
      busy_d = 1'b0;
    end
  end

  lspe_merge u_merge (
    .clk_i, .rst_ni, .start_i(merge_start), .level_i(levels), .thresh_i(thresh_q),
    .done_o(merge_done), .pos_o(pos), .count_o(count), .first_o(first), .last_o(last)
  );

  always_comb begin
    ovalid_d = ovalid_q;
    if (merge_done) ovalid_d = 1'b1;
    else if (m_axis_tready) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= lspe_pkg::ThreshReset;
      busy_q <= 1'b0; cnt_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) thresh_q <= cfg_data_i[lspe_pkg::LevelW-1:0];
      busy_q <= busy_d; cnt_q <= cnt_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge_done) begin
      odata_q <= {4'b0, levels[lspe_pkg::Channels-1], levels[0], last, first, count, pos};
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s_axis_tready) else $error("accepted while busy");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_done |-> busy_q) else $error("merge done while idle");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result lost");
`endif

endmodule
